>>> rtl/core/cpsf_pkg.sv
// shared types and constants for the charge port safety controller
`default_nettype none

package cpsf_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int TEMP_W    = 12;
    localparam int CURRENT_W = 10;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    localparam logic signed [TEMP_W-1:0] OVERTEMP_LIMIT_RST  = 12'sd900;
    localparam logic [COUNT_W-1:0]       COOLDOWN_FRAMES_RST = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERTEMP_LIMIT  = 1'b0,
        REG_COOLDOWN_FRAMES = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_CONNECTED = 3'd1,
        MODE_ARMING    = 3'd2,
        MODE_CHARGING  = 3'd3,
        MODE_FAULT     = 3'd4,
        MODE_COOLDOWN  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ORD_OPEN      = 3'd0,
        ORD_HOLD      = 3'd1,
        ORD_ADVERTISE = 3'd2,
        ORD_CLOSE     = 3'd3,
        ORD_ENERGIZE  = 3'd4
    } order_t;

    typedef enum logic [2:0] {
        FLT_NONE      = 3'd0,
        FLT_GROUND    = 3'd1,
        FLT_OVERTEMP  = 3'd2,
        FLT_PILOT     = 3'd3,
        FLT_CONTACTOR = 3'd4
    } fault_t;

    typedef enum logic [2:0] {
        PIL_A     = 3'd0,
        PIL_B     = 3'd1,
        PIL_C     = 3'd2,
        PIL_OTHER = 3'd3,
        PIL_F     = 3'd4
    } pilot_t;

    typedef enum logic [1:0] {
        PCLS_A   = 2'd0,
        PCLS_B   = 2'd1,
        PCLS_C   = 2'd2,
        PCLS_BAD = 2'd3
    } pilot_class_t;

    // frame after the stateless checks
    typedef struct packed {
        logic [2:0]           pilot_echo;
        logic [CURRENT_W-1:0] current;
        fault_t               pre_fault;
        pilot_class_t         pclass;
        logic                 feedback;
    } front_rec_t;

    typedef struct packed {
        mode_t                mode;
        order_t               order;
        logic [2:0]           pilot_echo;
        fault_t               fault_code;
        logic [CURRENT_W-1:0] current;
        logic [COUNT_W-1:0]   cooldown_left;
        logic                 close_request;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/cpsf_fifo.sv
// small register queue used between the front end, the back end and the result side
`default_nettype none

module cpsf_fifo
    import cpsf_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_ok;
    logic             rd_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_ok   = wr_en && !full;
    assign rd_ok   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_ok && !rd_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_ok && !wr_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

`default_nettype wire
endmodule

>>> rtl/core/cpsf_front.sv
// front end: takes frames in and runs the checks that need no state
`default_nettype none

module cpsf_front
    import cpsf_pkg::*;
(
    input  wire logic                        push,
    input  wire logic                        queue_full,
    input  wire logic [2:0]                  pilot_level,
    input  wire logic [CURRENT_W-1:0]        allowed_current,
    input  wire logic signed [TEMP_W-1:0]    temperature,
    input  wire logic                        ground_fault_ok,
    input  wire logic                        contactor_feedback,
    input  wire logic signed [TEMP_W-1:0]    overtemp_limit,
    output logic                             queue_write,
    output front_rec_t                       rec
);

    pilot_class_t pclass;
    fault_t       pre_fault;

    assign queue_write = push && !queue_full;

    always_comb
    begin
        case (pilot_level)
            PIL_A:   pclass = PCLS_A;
            PIL_B:   pclass = PCLS_B;
            PIL_C:   pclass = PCLS_C;
            default: pclass = PCLS_BAD;
        endcase
    end

    // priority: ground fault, overtemperature, pilot F
    always_comb
    begin
        if (!ground_fault_ok)
        begin
            pre_fault = FLT_GROUND;
        end
        else if (temperature >= overtemp_limit)
        begin
            pre_fault = FLT_OVERTEMP;
        end
        else if (pilot_level == PIL_F)
        begin
            pre_fault = FLT_PILOT;
        end
        else
        begin
            pre_fault = FLT_NONE;
        end
    end

    always_comb
    begin
        rec.pilot_echo = pilot_level;
        rec.current    = allowed_current;
        rec.pre_fault  = pre_fault;
        rec.pclass     = pclass;
        rec.feedback   = contactor_feedback;
    end

`default_nettype wire
endmodule

>>> rtl/core/cpsf_back.sv
// back end: mode state machine, cooldown counter and held fault
`default_nettype none

module cpsf_back
    import cpsf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire front_rec_t         rec,
    input  wire logic               rec_valid,
    output logic                    rec_take,
    input  wire logic               res_full,
    output logic                    res_write,
    output result_t                 res,
    input  wire logic [COUNT_W-1:0] cooldown_frames
);

    mode_t              mode_reg, mode_next;
    logic [COUNT_W-1:0] cool_reg, cool_next;
    fault_t             held_reg, held_next;

    mode_t              eff_mode;
    logic [COUNT_W-1:0] cool_dec;
    logic               fault_hit;
    fault_t             fault_sel;
    order_t             order;
    fault_t             fcode;
    logic [CURRENT_W-1:0] cur;
    logic               close;

    assign rec_take  = rec_valid && !res_full;
    assign res_write = rec_take;
    assign cool_dec  = (cool_reg != '0) ? cool_reg - 1'b1 : '0;

    always_comb
    begin
        mode_next = mode_reg;
        cool_next = cool_reg;
        held_next = held_reg;
        eff_mode  = mode_reg;
        fault_hit = 1'b0;
        fault_sel = FLT_NONE;
        order     = ORD_OPEN;
        fcode     = FLT_NONE;
        cur       = '0;
        close     = 1'b0;

        if (rec.pre_fault != FLT_NONE)
        begin
            fault_hit = 1'b1;
            fault_sel = rec.pre_fault;
        end
        else if (rec.feedback && (mode_reg inside {MODE_IDLE, MODE_CONNECTED,
                                                   MODE_COOLDOWN, MODE_FAULT}))
        begin
            fault_hit = 1'b1;
            fault_sel = FLT_CONTACTOR;
        end
        else
        begin
            // arming without pilot C drops back to connected
            if (mode_reg == MODE_ARMING && rec.pclass != PCLS_C)
            begin
                eff_mode = MODE_CONNECTED;
            end

            if (eff_mode == MODE_CHARGING && !rec.feedback)
            begin
                fault_hit = 1'b1;
                fault_sel = FLT_CONTACTOR;
            end
            else if (eff_mode == MODE_FAULT)
            begin
                mode_next = MODE_COOLDOWN;
                order     = ORD_HOLD;
                fcode     = held_reg;
            end
            else if (eff_mode == MODE_COOLDOWN && cool_dec != '0)
            begin
                mode_next = MODE_COOLDOWN;
                cool_next = cool_dec;
                order     = ORD_HOLD;
                fcode     = held_reg;
            end
            else
            begin
                // cooldown ending falls through to the pilot dispatch
                if (eff_mode == MODE_COOLDOWN)
                begin
                    cool_next = cool_dec;
                end
                held_next = FLT_NONE;
                case (rec.pclass)
                    PCLS_A:
                    begin
                        mode_next = MODE_IDLE;
                        order     = ORD_OPEN;
                    end
                    PCLS_B:
                    begin
                        mode_next = MODE_CONNECTED;
                        order     = ORD_ADVERTISE;
                        cur       = rec.current;
                    end
                    PCLS_C:
                    begin
                        cur = rec.current;
                        if (rec.feedback)
                        begin
                            mode_next = MODE_CHARGING;
                            order     = ORD_ENERGIZE;
                            close     = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_ARMING;
                            order     = ORD_CLOSE;
                        end
                    end
                    default:
                    begin
                        fault_hit = 1'b1;
                        fault_sel = FLT_PILOT;
                    end
                endcase
            end
        end

        if (fault_hit)
        begin
            mode_next = MODE_FAULT;
            held_next = fault_sel;
            cool_next = cooldown_frames;
            order     = ORD_OPEN;
            fcode     = fault_sel;
            cur       = '0;
            close     = 1'b0;
        end

        res.mode          = mode_next;
        res.order         = order;
        res.pilot_echo    = rec.pilot_echo;
        res.fault_code    = fcode;
        res.current       = cur;
        res.cooldown_left = cool_next;
        res.close_request = close;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cool_reg <= '0;
            held_reg <= FLT_NONE;
        end
        else if (rec_take)
        begin
            mode_reg <= mode_next;
            cool_reg <= cool_next;
            held_reg <= held_next;
        end
    end

    a_held_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ((mode_reg == MODE_FAULT) || (mode_reg == MODE_COOLDOWN)) == (held_reg != FLT_NONE))
        else $error("held fault out of step with mode");

    a_close_only_charging: assert property (@(posedge clk) disable iff (!rst_n)
        (res_write && res.close_request) |->
            (res.mode == MODE_CHARGING && res.order == ORD_ENERGIZE))
        else $error("contactor close outside charging");

    a_fault_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_take && mode_next == MODE_FAULT) |=>
            (mode_reg == MODE_FAULT && cool_reg == $past(cooldown_frames)))
        else $error("fault entry did not load cooldown count");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !rec_take |=> ($stable(mode_reg) && $stable(cool_reg) && $stable(held_reg)))
        else $error("state moved without a transfer");

`default_nettype wire
endmodule

>>> rtl/core/charge_port_safety_fsm.sv
// charge port safety controller: front checks, frame queue, state back end, result queue
// each frame goes from the frame queue through the back end into the result queue
// throughput: one frame per cycle unless the result queue is full
// the frame queue and the result queue each hold QUEUE_DEPTH entries
// reset (rst_n low, asynchronous): overtemp_limit 900, cooldown_frames 3,
// mode idle, cooldown count 0, no held fault, both queues empty
`default_nettype none

module charge_port_safety_fsm
    import cpsf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     push,
    output logic                          full,
    input  wire logic [2:0]               pilot_level,
    input  wire logic [CURRENT_W-1:0]     allowed_current,
    input  wire logic signed [TEMP_W-1:0] temperature,
    input  wire logic                     ground_fault_ok,
    input  wire logic                     contactor_feedback,

    output logic                          empty,
    input  wire logic                     pop,
    output logic [2:0]                    mode,
    output logic [2:0]                    order,
    output logic [2:0]                    pilot_echo,
    output logic [2:0]                    fault_code,
    output logic [CURRENT_W-1:0]          advertised_current,
    output logic [COUNT_W-1:0]            cooldown_left,
    output logic                          close_request,

    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DAT_W-1:0]     cfg_data
);

    localparam int REC_W = $bits(front_rec_t);
    localparam int RES_W = $bits(result_t);

    logic signed [TEMP_W-1:0] overtemp_limit_reg;
    logic [COUNT_W-1:0]       cooldown_frames_reg;

    front_rec_t        front_rec;
    logic              front_write;
    logic [REC_W-1:0]  queue_data;
    logic              queue_empty;
    logic              rec_take;
    logic              res_full;
    logic              res_write;
    result_t           back_res;
    logic [RES_W-1:0]  out_data;
    result_t           out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overtemp_limit_reg  <= OVERTEMP_LIMIT_RST;
            cooldown_frames_reg <= COOLDOWN_FRAMES_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_OVERTEMP_LIMIT:  overtemp_limit_reg  <= $signed(cfg_data[TEMP_W-1:0]);
                REG_COOLDOWN_FRAMES: cooldown_frames_reg <= cfg_data[COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    cpsf_front u_front (
        .push               (push),
        .queue_full         (full),
        .pilot_level        (pilot_level),
        .allowed_current    (allowed_current),
        .temperature        (temperature),
        .ground_fault_ok    (ground_fault_ok),
        .contactor_feedback (contactor_feedback),
        .overtemp_limit     (overtemp_limit_reg),
        .queue_write        (front_write),
        .rec                (front_rec)
    );

    cpsf_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_frame_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_write),
        .wr_data (front_rec),
        .full    (full),
        .rd_en   (rec_take),
        .rd_data (queue_data),
        .empty   (queue_empty)
    );

    cpsf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rec             (front_rec_t'(queue_data)),
        .rec_valid       (!queue_empty),
        .rec_take        (rec_take),
        .res_full        (res_full),
        .res_write       (res_write),
        .res             (back_res),
        .cooldown_frames (cooldown_frames_reg)
    );

    cpsf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_write),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_data),
        .empty   (empty)
    );

    assign out_res            = result_t'(out_data);
    assign mode               = out_res.mode;
    assign order              = out_res.order;
    assign pilot_echo         = out_res.pilot_echo;
    assign fault_code         = out_res.fault_code;
    assign advertised_current = out_res.current;
    assign cooldown_left      = out_res.cooldown_left;
    assign close_request      = out_res.close_request;

`default_nettype wire
endmodule

>>> test/tb_top.sv
// self-checking testbench for the charge port safety controller
`default_nettype none

module tb_top
    import cpsf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]                pilot;
        logic [CURRENT_W-1:0]      current;
        logic signed [TEMP_W-1:0]  temp;
        logic                      gf_ok;
        logic                      feedback;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                     push;
    logic                     full;
    logic [2:0]               pilot_level;
    logic [CURRENT_W-1:0]     allowed_current;
    logic signed [TEMP_W-1:0] temperature;
    logic                     ground_fault_ok;
    logic                     contactor_feedback;

    logic                     empty;
    logic                     pop;
    logic [2:0]               mode;
    logic [2:0]               order;
    logic [2:0]               pilot_echo;
    logic [2:0]               fault_code;
    logic [CURRENT_W-1:0]     advertised_current;
    logic [COUNT_W-1:0]       cooldown_left;
    logic                     close_request;

    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DAT_W-1:0]     cfg_data;

    // port controller state as the testbench tracks it
    logic signed [TEMP_W-1:0] cfg_overtemp_limit;
    logic [COUNT_W-1:0]       cfg_cooldown_frames;
    mode_t                    port_mode;
    logic [COUNT_W-1:0]       cooldown_count;
    fault_t                   held_fault;

    result_t pending_responses[$];
    int      mismatch_count = 0;
    int      sender_burst = 0;
    int      receiver_burst = 0;

    charge_port_safety_fsm dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .pilot_level        (pilot_level),
        .allowed_current    (allowed_current),
        .temperature        (temperature),
        .ground_fault_ok    (ground_fault_ok),
        .contactor_feedback (contactor_feedback),
        .empty              (empty),
        .pop                (pop),
        .mode               (mode),
        .order              (order),
        .pilot_echo         (pilot_echo),
        .fault_code         (fault_code),
        .advertised_current (advertised_current),
        .cooldown_left      (cooldown_left),
        .close_request      (close_request),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idle cycles before the next transfer, with runs of back-to-back traffic
    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic result_t make_response(mode_t m, order_t o, logic [2:0] pil, fault_t fc,
                                              logic [CURRENT_W-1:0] cur, logic [COUNT_W-1:0] cnt,
                                              logic cl);
        result_t r;
        r.mode          = m;
        r.order         = o;
        r.pilot_echo    = pil;
        r.fault_code    = fc;
        r.current       = cur;
        r.cooldown_left = cnt;
        r.close_request = cl;
        return r;
    endfunction

    task automatic compute_port_response(input frame_t f, output result_t r);
        fault_t trip;
        bit     done;
        trip = FLT_NONE;
        done = 1'b0;
        if (!f.gf_ok)
            trip = FLT_GROUND;
        else if (f.temp >= cfg_overtemp_limit)
            trip = FLT_OVERTEMP;
        else if (f.pilot == PIL_F)
            trip = FLT_PILOT;
        else if (f.feedback && (port_mode == MODE_IDLE || port_mode == MODE_CONNECTED ||
                                port_mode == MODE_COOLDOWN || port_mode == MODE_FAULT))
            trip = FLT_CONTACTOR;
        else
        begin
            // arming drops back unless pilot still reads C
            if (port_mode == MODE_ARMING && f.pilot != PIL_C)
                port_mode = MODE_CONNECTED;
            if (port_mode == MODE_CHARGING && !f.feedback)
                trip = FLT_CONTACTOR;
        end

        if (trip == FLT_NONE && port_mode == MODE_FAULT)
        begin
            port_mode = MODE_COOLDOWN;
            r = make_response(MODE_COOLDOWN, ORD_HOLD, f.pilot, held_fault, '0,
                              cooldown_count, 1'b0);
            done = 1'b1;
        end
        else if (trip == FLT_NONE && port_mode == MODE_COOLDOWN)
        begin
            if (cooldown_count != 0)
                cooldown_count--;
            if (cooldown_count != 0)
            begin
                r = make_response(MODE_COOLDOWN, ORD_HOLD, f.pilot, held_fault, '0,
                                  cooldown_count, 1'b0);
                done = 1'b1;
            end
            else
            begin
                port_mode  = MODE_IDLE;
                held_fault = FLT_NONE;
            end
        end

        if (trip == FLT_NONE && !done)
        begin
            case (f.pilot)
                PIL_A:
                begin
                    port_mode  = MODE_IDLE;
                    held_fault = FLT_NONE;
                    r = make_response(MODE_IDLE, ORD_OPEN, f.pilot, FLT_NONE, '0,
                                      cooldown_count, 1'b0);
                end
                PIL_B:
                begin
                    port_mode  = MODE_CONNECTED;
                    held_fault = FLT_NONE;
                    r = make_response(MODE_CONNECTED, ORD_ADVERTISE, f.pilot, FLT_NONE,
                                      f.current, cooldown_count, 1'b0);
                end
                PIL_C:
                begin
                    held_fault = FLT_NONE;
                    if (f.feedback)
                    begin
                        port_mode = MODE_CHARGING;
                        r = make_response(MODE_CHARGING, ORD_ENERGIZE, f.pilot, FLT_NONE,
                                          f.current, cooldown_count, 1'b1);
                    end
                    else
                    begin
                        port_mode = MODE_ARMING;
                        r = make_response(MODE_ARMING, ORD_CLOSE, f.pilot, FLT_NONE,
                                          f.current, cooldown_count, 1'b0);
                    end
                end
                default: trip = FLT_PILOT;
            endcase
        end

        if (trip != FLT_NONE)
        begin
            port_mode      = MODE_FAULT;
            held_fault     = trip;
            cooldown_count = cfg_cooldown_frames;
            r = make_response(MODE_FAULT, ORD_OPEN, f.pilot, trip, '0, cooldown_count, 1'b0);
        end
    endtask

    task automatic send_frame(input frame_t f);
        int      gap;
        result_t r;
        gap = draw_wait(sender_burst);
        if (gap != 0)
        begin
            @(negedge clk) push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push               <= 1'b1;
        pilot_level        <= f.pilot;
        allowed_current    <= f.current;
        temperature        <= f.temp;
        ground_fault_ok    <= f.gf_ok;
        contactor_feedback <= f.feedback;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        compute_port_response(f, r);
        pending_responses.push_back(r);
    endtask

    // stop sending and let every outstanding response come back
    task automatic wait_results_drained();
        @(negedge clk) push <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_OVERTEMP_LIMIT)
            cfg_overtemp_limit = value;
        else
            cfg_cooldown_frames = value[COUNT_W-1:0];
        @(negedge clk) cfg_write <= 1'b0;
    endtask

    task automatic make_frame(output frame_t f);
        int lo;
        int hi;
        int pick;
        if ($urandom_range(0, 99) < 15)
        begin
            // noise across the whole encoding of every field
            f.pilot    = 3'($urandom);
            f.current  = CURRENT_W'($urandom);
            f.temp     = TEMP_W'($urandom);
            f.gf_ok    = 1'($urandom);
            f.feedback = 1'($urandom);
            return;
        end
        f.gf_ok   = ($urandom_range(0, 39) != 0);
        f.current = CURRENT_W'($urandom_range(0, 800));
        hi = int'(cfg_overtemp_limit) - 1;
        if ($urandom_range(0, 19) == 0 || hi < -2048)
            f.temp = TEMP_W'(int'(cfg_overtemp_limit) +
                     int'($urandom_range(0, 2047 - int'(cfg_overtemp_limit))));
        else
        begin
            lo = (hi >= -400) ? -400 : -2048;
            f.temp = TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            f.pilot = PIL_A;
        else if (pick < 40)
            f.pilot = PIL_B;
        else if (pick < 90)
            f.pilot = PIL_C;
        else if (pick < 94)
            f.pilot = PIL_F;
        else
            f.pilot = $urandom_range(0, 1) ? 3'(PIL_OTHER) : 3'($urandom_range(5, 7));
        // keep the contactor consistent with the arming/charging path most of the time
        if (f.pilot == PIL_C && (port_mode == MODE_ARMING || port_mode == MODE_CHARGING))
            f.feedback = ($urandom_range(0, 9) != 0);
        else
            f.feedback = ($urandom_range(0, 19) == 0);
    endtask

    task automatic test_pilot_dispatch();
        send_frame(frame_t'{PIL_A, 10'd0,    -12'sd400, 1'b1, 1'b0});
        send_frame(frame_t'{PIL_B, 10'd800,  12'sd899,  1'b1, 1'b0});
        send_frame(frame_t'{PIL_C, 10'd1023, 12'sd0,    1'b1, 1'b0});
        // arming without pilot C falls back to connected
        send_frame(frame_t'{PIL_B, 10'd512,  12'sd100,  1'b1, 1'b0});
        send_frame(frame_t'{PIL_C, 10'd321,  12'sd100,  1'b1, 1'b0});
        send_frame(frame_t'{PIL_C, 10'd800,  12'sd100,  1'b1, 1'b1});
        // contactor opens while charging
        send_frame(frame_t'{PIL_C, 10'd800,  12'sd100,  1'b1, 1'b0});
        repeat (4) send_frame(frame_t'{PIL_A, 10'd7, 12'sd20, 1'b1, 1'b0});
    endtask

    task automatic test_fault_priority();
        // contactor sensed closed while idle
        send_frame(frame_t'{PIL_A, 10'd0,   12'sd0,     1'b1, 1'b1});
        send_frame(frame_t'{PIL_F, 10'd100, 12'sd2047,  1'b0, 1'b1});
        send_frame(frame_t'{PIL_F, 10'd100, 12'sd900,   1'b1, 1'b0});
        send_frame(frame_t'{PIL_F, 10'd100, 12'sd899,   1'b1, 1'b0});
    endtask

    task automatic test_zero_cooldown();
        wait_results_drained();
        write_reg(REG_COOLDOWN_FRAMES, 12'd0);
        send_frame(frame_t'{PIL_B, 10'd55, 12'sd0, 1'b0, 1'b0});
        send_frame(frame_t'{PIL_B, 10'd55, 12'sd0, 1'b1, 1'b0});
        send_frame(frame_t'{PIL_B, 10'd55, 12'sd0, 1'b1, 1'b0});
    endtask

    task automatic test_bad_pilot();
        send_frame(frame_t'{PIL_OTHER, 10'd1, -12'sd2048, 1'b1, 1'b0});
        send_frame(frame_t'{3'd5,      10'd2, 12'sd0,     1'b1, 1'b0});
        send_frame(frame_t'{3'd6,      10'd3, 12'sd0,     1'b1, 1'b0});
        send_frame(frame_t'{3'd7,      10'd4, 12'sd0,     1'b1, 1'b0});
        send_frame(frame_t'{3'd7,      10'd5, 12'sd0,     1'b1, 1'b0});
    endtask

    task automatic run_random_phase(input logic [CFG_DAT_W-1:0] limit,
                                    input logic [CFG_DAT_W-1:0] frames, input int count);
        frame_t f;
        wait_results_drained();
        write_reg(REG_OVERTEMP_LIMIT, limit);
        write_reg(REG_COOLDOWN_FRAMES, frames);
        for (int i = 0; i < count; i++)
        begin
            make_frame(f);
            send_frame(f);
            // hold the sender off once mid-phase until the results side catches up
            if (i == count / 2)
                wait_results_drained();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(12'd900, 12'd3, 150);
        run_random_phase(12'($urandom_range(0, 2400) - 400), 12'($urandom_range(0, 8)), 150);
        run_random_phase(12'h7FF, 12'd0, 100);
        run_random_phase(12'h800, 12'd255, 30);
        run_random_phase(12'($urandom_range(0, 2400) - 400), 12'd1, 120);
    endtask

    // results side: random pop stalls, every transfer compared with the oldest prediction
    initial
    begin : response_checker
        int      stall;
        result_t got;
        result_t want;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(receiver_burst);
            if (stall != 0)
            begin
                @(negedge clk) pop <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) pop <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (!empty)
                    break;
            end
            got = make_response(mode_t'(mode), order_t'(order), pilot_echo,
                                fault_t'(fault_code), advertised_current, cooldown_left,
                                close_request);
            if (pending_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: mode %0d order %0d fault %0d",
                             got.mode, got.order, got.fault_code);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (got.mode !== want.mode || got.order !== want.order ||
                    got.pilot_echo !== want.pilot_echo || got.fault_code !== want.fault_code ||
                    got.current !== want.current || got.cooldown_left !== want.cooldown_left ||
                    got.close_request !== want.close_request)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp mode %0d order %0d pilot %0d fault %0d ",
                                  "cur %0d cool %0d close %0d, got %0d %0d %0d %0d %0d %0d %0d"},
                                 want.mode, want.order, want.pilot_echo, want.fault_code,
                                 want.current, want.cooldown_left, want.close_request,
                                 got.mode, got.order, got.pilot_echo, got.fault_code,
                                 got.current, got.cooldown_left, got.close_request);
                end
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        push               <= 1'b0;
        pilot_level        <= '0;
        allowed_current    <= '0;
        temperature        <= '0;
        ground_fault_ok    <= 1'b1;
        contactor_feedback <= 1'b0;
        cfg_write          <= 1'b0;
        cfg_index          <= REG_OVERTEMP_LIMIT;
        cfg_data           <= '0;
        cfg_overtemp_limit  = OVERTEMP_LIMIT_RST;
        cfg_cooldown_frames = COOLDOWN_FRAMES_RST;
        port_mode           = MODE_IDLE;
        cooldown_count      = '0;
        held_fault          = FLT_NONE;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_pilot_dispatch();
        test_fault_priority();
        test_zero_cooldown();
        test_bad_pilot();
        test_random_traffic();
        wait_results_drained();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
